// ===== hdl/wms_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wms_pkg: shared types and constants of the wave mesh stencil
// grid geometry, value format, register and mode codes, command record
// ----------------------------------------------------------------------------
package wms_pkg;

  localparam int GRID_SIZE       = 64;
  localparam int VALUE_BITS      = 16;
  localparam int COORD_BITS      = $clog2(GRID_SIZE);
  localparam int ADDR_BITS       = 2 * COORD_BITS;
  localparam int CELLS           = GRID_SIZE * GRID_SIZE;
  localparam int CFG_BITS        = 16;
  localparam int CFG_INDEX_BITS  = 1;
  localparam int CMD_QUEUE_DEPTH = 2;
  localparam int SAT_BITS        = 48;

  localparam logic [CFG_BITS-1:0] COUPLING_RESET = 16'd6554;
  localparam logic [CFG_BITS-1:0] DIFFUSE_RESET  = 16'd3277;

  localparam logic [CFG_INDEX_BITS-1:0] REG_COUPLING = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DIFFUSE  = 1'b1;

  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_STRIKE = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;

  typedef struct packed {
    logic [1:0]                   kind;
    logic [COORD_BITS-1:0]        row;
    logic [COORD_BITS-1:0]        col;
    logic [COORD_BITS-1:0]        r_lo;
    logic [COORD_BITS-1:0]        r_hi;
    logic [COORD_BITS-1:0]        c_lo;
    logic [COORD_BITS-1:0]        c_hi;
    logic                         empty;
    logic signed [VALUE_BITS-1:0] strike_value;
    logic signed [VALUE_BITS-1:0] prior_add;
    logic signed [VALUE_BITS-1:0] slope_row;
    logic signed [VALUE_BITS-1:0] slope_col;
  } cmd_t;

  function automatic logic [VALUE_BITS-1:0] sat_value(input logic signed [SAT_BITS-1:0] x);
    logic signed [SAT_BITS-1:0] hi;
    logic signed [SAT_BITS-1:0] lo;
    hi = (SAT_BITS'(64'sd1) <<< (VALUE_BITS - 1)) - SAT_BITS'(64'sd1);
    lo = -hi - SAT_BITS'(64'sd1);
    if (x > hi) begin
      sat_value = hi[VALUE_BITS-1:0];
    end else if (x < lo) begin
      sat_value = lo[VALUE_BITS-1:0];
    end else begin
      sat_value = x[VALUE_BITS-1:0];
    end
  endfunction

  function automatic logic is_inner(input logic [ADDR_BITS-1:0] k);
    logic [COORD_BITS-1:0] r;
    logic [COORD_BITS-1:0] c;
    r = k[ADDR_BITS-1:COORD_BITS];
    c = k[COORD_BITS-1:0];
    is_inner = (r != '0) && (r != COORD_BITS'(GRID_SIZE - 1)) &&
               (c != '0) && (c != COORD_BITS'(GRID_SIZE - 1));
  endfunction

endpackage
`default_nettype wire

// ===== hdl/wms_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wms_in_if: command channel
// valid/ready handshake carrying one tick, strike or read command
// ----------------------------------------------------------------------------
interface wms_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [5:0]        row;
  logic [5:0]        col;
  logic [1:0]        half_size;
  logic signed [15:0] strike_value;
  logic signed [15:0] prior_add;
  logic signed [15:0] slope_row;
  logic signed [15:0] slope_col;

  modport source (output valid, mode, row, col, half_size, strike_value, prior_add,
                  slope_row, slope_col, input ready);
  modport sink (input valid, mode, row, col, half_size, strike_value, prior_add,
                slope_row, slope_col, output ready);
endinterface
`default_nettype wire

// ===== hdl/wms_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wms_out_if: result channel
// valid/ready handshake carrying the current and previous value of a cell
// ----------------------------------------------------------------------------
interface wms_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] cell_value;
  logic signed [15:0] prior_value;

  modport source (output valid, cell_value, prior_value, input ready);
  modport sink (input valid, cell_value, prior_value, output ready);
endinterface
`default_nettype wire

// ===== hdl/wms_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wms_ram: simple dual port ram
// one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module wms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/wms_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wms_front: command intake
// accepts commands, clips strike patches to the inner grid, queues them
// ----------------------------------------------------------------------------
module wms_front import wms_pkg::*; (
  wms_in_if.sink     cmd,
  input  wire logic  busy,
  input  wire logic  queue_full,
  output logic       push,
  output cmd_t       push_cmd
);

  localparam logic [COORD_BITS-1:0] LAST_INNER = COORD_BITS'(GRID_SIZE - 2);
  localparam logic [COORD_BITS-1:0] FIRST_INNER = COORD_BITS'(1);

  logic [COORD_BITS-1:0] half;
  logic [COORD_BITS:0]   row_up;
  logic [COORD_BITS:0]   col_up;
  logic [COORD_BITS-1:0] r_lo;
  logic [COORD_BITS-1:0] r_hi;
  logic [COORD_BITS-1:0] c_lo;
  logic [COORD_BITS-1:0] c_hi;

  assign cmd.ready = !busy && !queue_full;

  always_comb begin
    half   = COORD_BITS'(cmd.half_size);
    row_up = {1'b0, cmd.row} + {1'b0, half};
    col_up = {1'b0, cmd.col} + {1'b0, half};
    r_lo   = (cmd.row > half) ? cmd.row - half : FIRST_INNER;
    c_lo   = (cmd.col > half) ? cmd.col - half : FIRST_INNER;
    r_hi   = (row_up > {1'b0, LAST_INNER}) ? LAST_INNER : row_up[COORD_BITS-1:0];
    c_hi   = (col_up > {1'b0, LAST_INNER}) ? LAST_INNER : col_up[COORD_BITS-1:0];
  end

  always_comb begin
    push_cmd.kind         = cmd.mode;
    push_cmd.row          = cmd.row;
    push_cmd.col          = cmd.col;
    push_cmd.r_lo         = r_lo;
    push_cmd.r_hi         = r_hi;
    push_cmd.c_lo         = c_lo;
    push_cmd.c_hi         = c_hi;
    push_cmd.empty        = (r_lo > r_hi) || (c_lo > c_hi);
    push_cmd.strike_value = cmd.strike_value;
    push_cmd.prior_add    = cmd.prior_add;
    push_cmd.slope_row    = cmd.slope_row;
    push_cmd.slope_col    = cmd.slope_col;
  end

  // unused mode code is taken and dropped
  assign push = cmd.valid && cmd.ready && (cmd.mode != MODE_NONE);

endmodule
`default_nettype wire

// ===== hdl/wms_cmd_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wms_cmd_fifo: command queue
// short register queue between command intake and grid engine
// ----------------------------------------------------------------------------
module wms_cmd_fifo import wms_pkg::*; #(
  parameter int DEPTH = CMD_QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      nonempty,
  output cmd_t      head
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  cmd_t                slots [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign full     = (count == CNT_BITS'(DEPTH));
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("command queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !nonempty |-> !pop)
    else $error("command queue underflow");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("command queue count mismatch");

endmodule
`default_nettype wire

// ===== hdl/wms_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wms_engine: grid engine
// two swapping banks; raster scan stencil pipeline, patch writer, cell read
// ----------------------------------------------------------------------------
module wms_engine import wms_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_BITS-1:0]       cfg_data,
  input  wire logic                      q_valid,
  input  wire cmd_t                      q_cmd,
  output logic                           q_pop,
  output logic                           busy,
  wms_out_if.source                      result
);

  localparam logic [2:0] ST_CLEAR     = 3'd0;
  localparam logic [2:0] ST_IDLE      = 3'd1;
  localparam logic [2:0] ST_TICK      = 3'd2;
  localparam logic [2:0] ST_STRIKE    = 3'd3;
  localparam logic [2:0] ST_READ      = 3'd4;
  localparam logic [2:0] ST_READ_WAIT = 3'd5;

  localparam int WIN_LEN   = 2 * GRID_SIZE + 3;
  localparam int SUM_BITS  = VALUE_BITS + 5;
  localparam int AVG_BITS  = SUM_BITS - 4;
  localparam int PROD_BITS = CFG_BITS + 1 + SUM_BITS;
  localparam int NX_BITS   = SUM_BITS + 3;
  localparam int BL_BITS   = CFG_BITS + 2 + NX_BITS + 2;
  localparam int STR_BITS  = VALUE_BITS + 6;

  localparam logic signed [PROD_BITS-1:0] PROD_HALF = PROD_BITS'(64'sd1 <<< (CFG_BITS - 1));
  localparam logic signed [BL_BITS-1:0]   BL_HALF   = BL_BITS'(64'sd1 <<< (CFG_BITS - 1));
  localparam logic signed [SUM_BITS-1:0]  SUM_HALF  = SUM_BITS'(64'sd8);
  localparam logic [ADDR_BITS-1:0]        LAG       = ADDR_BITS'(GRID_SIZE + 1);
  localparam logic [CFG_BITS:0]           UNITY     = (CFG_BITS + 1)'(1 << CFG_BITS);

  logic [2:0]             state;
  logic [ADDR_BITS:0]     cnt;
  logic                   cur_sel;
  logic [CFG_BITS-1:0]    coupling;
  logic [CFG_BITS-1:0]    diffuse_weight;
  cmd_t                   op;
  logic [COORD_BITS-1:0]  str_row;
  logic [COORD_BITS-1:0]  str_col;

  // bank ports seen as current and previous grid
  logic                   cur_we, prev_we;
  logic [ADDR_BITS-1:0]   cur_waddr, prev_waddr, cur_raddr, prev_raddr;
  logic [VALUE_BITS-1:0]  cur_wdata, prev_wdata;
  logic signed [VALUE_BITS-1:0] cur_rdata, prev_rdata;
  logic                   b_we    [2];
  logic [ADDR_BITS-1:0]   b_waddr [2];
  logic [ADDR_BITS-1:0]   b_raddr [2];
  logic [VALUE_BITS-1:0]  b_wdata [2];
  logic [VALUE_BITS-1:0]  b_rdata [2];

  // stencil pipeline
  logic                   tick_issue;
  logic                   d_scan, d_kv, e_kv, f_valid, g_valid, h_valid, j_valid;
  logic [ADDR_BITS-1:0]   d_k, e_k, f_k, g_k, h_k, j_k;
  logic signed [VALUE_BITS-1:0] e_prev;
  logic signed [VALUE_BITS-1:0] win [WIN_LEN];
  logic signed [SUM_BITS-1:0]   e_m, e_n4, e_dg;
  logic signed [SUM_BITS-1:0]   f_lap, f_sum9, f_tmp, g_sum9, g_tmp;
  logic signed [PROD_BITS-1:0]  f_prod, g_prod, g_adj;
  logic signed [SUM_BITS-1:0]   g_avgw;
  logic signed [NX_BITS-1:0]    g_nx, h_nx;
  logic signed [AVG_BITS-1:0]   h_avg;
  logic [CFG_BITS:0]            w_cur;
  logic signed [BL_BITS-1:0]    h_p1, h_p2, j_p1, j_p2, j_bl;
  logic [VALUE_BITS-1:0]        j_res;

  // patch writer
  logic                   s_valid;
  logic [ADDR_BITS-1:0]   s_addr;
  logic signed [2:0]      s_dr, s_dc;
  logic signed [STR_BITS-1:0] s_sum;
  logic [VALUE_BITS-1:0]  s_new;

  logic                   out_valid;
  logic [VALUE_BITS-1:0]  out_cell, out_prior;

  assign busy       = (state == ST_CLEAR);
  assign tick_issue = (state == ST_TICK) && !cnt[ADDR_BITS];
  assign q_pop      = (state == ST_IDLE) && q_valid && !s_valid &&
                      ((q_cmd.kind != MODE_READ) || !out_valid);

  assign result.valid       = out_valid;
  assign result.cell_value  = out_cell;
  assign result.prior_value = out_prior;

  // ---------------------------------------------------------------- banks
  for (genvar b = 0; b < 2; b++) begin : g_bank
    wms_ram #(.WIDTH(VALUE_BITS), .DEPTH(CELLS)) u_ram (
      .clk   (clk),
      .we    (b_we[b]),
      .waddr (b_waddr[b]),
      .wdata (b_wdata[b]),
      .raddr (b_raddr[b]),
      .rdata (b_rdata[b])
    );
  end

  always_comb begin
    b_we[0]    = cur_sel ? prev_we    : cur_we;
    b_waddr[0] = cur_sel ? prev_waddr : cur_waddr;
    b_wdata[0] = cur_sel ? prev_wdata : cur_wdata;
    b_raddr[0] = cur_sel ? prev_raddr : cur_raddr;
    b_we[1]    = cur_sel ? cur_we     : prev_we;
    b_waddr[1] = cur_sel ? cur_waddr  : prev_waddr;
    b_wdata[1] = cur_sel ? cur_wdata  : prev_wdata;
    b_raddr[1] = cur_sel ? cur_raddr  : prev_raddr;
    cur_rdata  = cur_sel ? b_rdata[1] : b_rdata[0];
    prev_rdata = cur_sel ? b_rdata[0] : b_rdata[1];
  end

  always_comb begin
    cur_we     = 1'b0;
    prev_we    = 1'b0;
    cur_waddr  = '0;
    prev_waddr = '0;
    cur_wdata  = '0;
    prev_wdata = '0;
    cur_raddr  = '0;
    prev_raddr = '0;
    unique case (state)
      ST_CLEAR: begin
        cur_we     = 1'b1;
        prev_we    = 1'b1;
        cur_waddr  = cnt[ADDR_BITS-1:0];
        prev_waddr = cnt[ADDR_BITS-1:0];
      end
      ST_TICK: begin
        cur_raddr  = cnt[ADDR_BITS-1:0];
        prev_raddr = cnt[ADDR_BITS-1:0] - LAG;
      end
      ST_STRIKE: begin
        prev_raddr = {str_row, str_col};
      end
      ST_READ: begin
        cur_raddr  = {op.row, op.col};
        prev_raddr = {op.row, op.col};
      end
      default: ;
    endcase
    // new values go into the previous bank behind the scan, banks swap at the end
    if (j_valid) begin
      prev_we    = 1'b1;
      prev_waddr = j_k;
      prev_wdata = j_res;
    end
    if (s_valid) begin
      cur_we     = 1'b1;
      cur_waddr  = s_addr;
      cur_wdata  = op.strike_value;
      prev_we    = 1'b1;
      prev_waddr = s_addr;
      prev_wdata = s_new;
    end
  end

  // ---------------------------------------------------------------- stencil
  always_comb begin
    e_m  = SUM_BITS'(win[GRID_SIZE + 1]);
    e_n4 = SUM_BITS'(win[2 * GRID_SIZE + 1]) + SUM_BITS'(win[1]) +
           SUM_BITS'(win[GRID_SIZE + 2]) + SUM_BITS'(win[GRID_SIZE]);
    e_dg = SUM_BITS'(win[2 * GRID_SIZE + 2]) + SUM_BITS'(win[2 * GRID_SIZE]) +
           SUM_BITS'(win[2]) + SUM_BITS'(win[0]);
    f_prod = $signed({1'b0, coupling}) * f_lap;
    g_adj  = (g_prod + PROD_HALF) >>> CFG_BITS;
    g_nx   = NX_BITS'(g_tmp) + NX_BITS'(g_adj);
    g_avgw = (g_sum9 + SUM_HALF) >>> 4;
    w_cur  = UNITY - {1'b0, diffuse_weight};
    h_p1   = $signed({1'b0, w_cur}) * h_nx;
    h_p2   = $signed({1'b0, diffuse_weight}) * h_avg;
    j_bl   = (j_p1 + j_p2 + BL_HALF) >>> CFG_BITS;
    j_res  = sat_value(SAT_BITS'(j_bl));
    s_sum  = STR_BITS'(prev_rdata) + STR_BITS'(op.prior_add) +
             STR_BITS'(op.slope_row) * STR_BITS'(s_dr) +
             STR_BITS'(op.slope_col) * STR_BITS'(s_dc);
    s_new  = sat_value(SAT_BITS'(s_sum));
  end

  always_ff @(posedge clk) begin
    if (d_scan) begin
      win[0] <= cur_rdata;
      for (int j = 1; j < WIN_LEN; j++) begin
        win[j] <= win[j-1];
      end
    end
    d_k    <= cnt[ADDR_BITS-1:0] - LAG;
    e_k    <= d_k;
    e_prev <= prev_rdata;
    f_k    <= e_k;
    f_lap  <= e_n4 - (e_m <<< 2);
    f_sum9 <= (e_m <<< 3) + e_n4 + e_dg;
    f_tmp  <= (e_m <<< 1) - SUM_BITS'(e_prev);
    g_k    <= f_k;
    g_prod <= f_prod;
    g_sum9 <= f_sum9;
    g_tmp  <= f_tmp;
    h_k    <= g_k;
    h_nx   <= g_nx;
    h_avg  <= AVG_BITS'(g_avgw);
    j_k    <= h_k;
    j_p1   <= h_p1;
    j_p2   <= h_p2;
    s_addr <= {str_row, str_col};
    s_dr   <= 3'(str_row - op.row);
    s_dc   <= 3'(str_col - op.col);
    if (state == ST_READ_WAIT) begin
      out_cell  <= cur_rdata;
      out_prior <= prev_rdata;
    end
  end

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      cnt            <= '0;
      cur_sel        <= 1'b0;
      coupling       <= COUPLING_RESET;
      diffuse_weight <= DIFFUSE_RESET;
      out_valid      <= 1'b0;
      d_scan         <= 1'b0;
      d_kv           <= 1'b0;
      e_kv           <= 1'b0;
      f_valid        <= 1'b0;
      g_valid        <= 1'b0;
      h_valid        <= 1'b0;
      j_valid        <= 1'b0;
      s_valid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_COUPLING: coupling       <= cfg_data;
          REG_DIFFUSE:  diffuse_weight <= cfg_data;
          default: ;
        endcase
      end
      if (result.valid && result.ready) begin
        out_valid <= 1'b0;
      end
      d_scan  <= tick_issue;
      d_kv    <= tick_issue && (cnt >= (ADDR_BITS + 1)'(GRID_SIZE + 1));
      e_kv    <= d_kv;
      f_valid <= e_kv && is_inner(e_k);
      g_valid <= f_valid;
      h_valid <= g_valid;
      j_valid <= h_valid;
      s_valid <= (state == ST_STRIKE);
      unique case (state)
        ST_CLEAR: begin
          if (cnt[ADDR_BITS-1:0] == '1) begin
            cnt   <= '0;
            state <= ST_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_IDLE: begin
          if (q_pop) begin
            op      <= q_cmd;
            str_row <= q_cmd.r_lo;
            str_col <= q_cmd.c_lo;
            unique case (q_cmd.kind)
              MODE_TICK: begin
                cnt   <= '0;
                state <= ST_TICK;
              end
              MODE_STRIKE: begin
                if (!q_cmd.empty) begin
                  state <= ST_STRIKE;
                end
              end
              MODE_READ: state <= ST_READ;
              default: ;
            endcase
          end
        end
        ST_TICK: begin
          if (!cnt[ADDR_BITS]) begin
            cnt <= cnt + 1'b1;
          end else if (!d_scan && !e_kv && !f_valid && !g_valid && !h_valid && !j_valid) begin
            cur_sel <= !cur_sel;
            state   <= ST_IDLE;
          end
        end
        ST_STRIKE: begin
          if (str_col == op.c_hi) begin
            str_col <= op.c_lo;
            if (str_row == op.r_hi) begin
              state <= ST_IDLE;
            end else begin
              str_row <= str_row + 1'b1;
            end
          end else begin
            str_col <= str_col + 1'b1;
          end
        end
        ST_READ: state <= ST_READ_WAIT;
        ST_READ_WAIT: begin
          out_valid <= 1'b1;
          state     <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_read_slot_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ_WAIT) |-> !out_valid)
    else $error("read result would overwrite a pending result");
  a_swap_after_tick: assert property (@(posedge clk) disable iff (rst)
    (cur_sel != $past(cur_sel)) |-> ($past(state) == ST_TICK))
    else $error("bank swap outside a tick");
  a_single_writer: assert property (@(posedge clk) disable iff (rst)
    !(j_valid && s_valid))
    else $error("stencil and patch writes collide");
  a_patch_inner: assert property (@(posedge clk) disable iff (rst)
    s_valid |-> is_inner(s_addr))
    else $error("patch write on the border");

endmodule
`default_nettype wire

// ===== hdl/wave_mesh_stencil_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wave_mesh_stencil_step: 2-D leapfrog wave mesh
// Commands enter on cmd (valid/ready): tick, strike patch or read cell.
// Reads return cell_value and prior_value on result (valid/ready).
// Coupling and diffuse weight are written through cfg_we/cfg_index/cfg_data;
// the user must do so only while the block is idle; this is not enforced.
// A read leaves the queue, then passes the read and read-wait states;
// its result is registered.
// A strike writes its patch one cell at a time, row by row, at most 7 by 7.
// A tick scans the grid once from the current bank, one cell per cycle,
// through a two-row line window.
// Commands are queued two deep, so the intake keeps accepting while the
// engine works or a read result waits, until the queue is full.
// After reset both banks are cleared one cell per cycle with cmd.ready low;
// configuration writes are taken during that time.
// When the receiver stalls, a read result is held; later reads wait for it.
// ----------------------------------------------------------------------------
module wave_mesh_stencil_step import wms_pkg::*; #(
  parameter int QUEUE_DEPTH = CMD_QUEUE_DEPTH
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  wms_in_if.sink                         cmd,
  wms_out_if.source                      result,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_BITS-1:0]       cfg_data
);

  logic busy;
  logic queue_full;
  logic push;
  cmd_t push_cmd;
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  wms_front u_front (
    .cmd        (cmd),
    .busy       (busy),
    .queue_full (queue_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  wms_cmd_fifo #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (queue_full),
    .pop      (q_pop),
    .nonempty (q_valid),
    .head     (q_cmd)
  );

  wms_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .busy      (busy),
    .result    (result)
  );

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: testbench of the wave mesh stencil
// Drives tick, strike, read and no-op commands with random gaps and result stalls,
// tracks both grids in a local mesh model and checks each read against it.
// ----------------------------------------------------------------------------
module tb_top;
  import wms_pkg::*;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0] cfg_data;

  wms_in_if  cmd_ch ();
  wms_out_if res_ch ();

  wave_mesh_stencil_step u_top (
    .clk(clk), .rst(rst), .cmd(cmd_ch), .result(res_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  typedef struct {
    logic signed [15:0] cell_value;
    logic signed [15:0] prior_value;
  } cell_read_t;

  // mesh model: current and previous displacement, row-major
  longint mesh_cur [0:CELLS-1];
  longint mesh_prv [0:CELLS-1];
  longint mesh_nxt [0:CELLS-1];
  longint coupling_q;
  longint diffuse_q;

  cell_read_t pending_reads[$];
  int errors;
  int n_ticks, n_strikes, n_reads, n_checked, n_idle_cmds;
  bit calm;
  int last_r, last_c;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("timeout at %0t", $time);
    $display("[wave_mesh_stencil_step] ERROR");
    $finish;
  end

  function automatic longint sat16(input longint x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return x;
  endfunction

  // round half up, then drop s fraction bits
  function automatic longint rnd_drop(input longint x, input int s);
    return (x + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic void mesh_tick();
    longint m, n4, dg, lap, nx, avg, bl;
    int k;
    for (int i = 0; i < CELLS; i++) mesh_nxt[i] = mesh_cur[i];
    for (int r = 1; r < GRID_SIZE - 1; r++) begin
      for (int c = 1; c < GRID_SIZE - 1; c++) begin
        k = r * GRID_SIZE + c;
        m = mesh_cur[k];
        n4 = mesh_cur[k-GRID_SIZE] + mesh_cur[k+GRID_SIZE] + mesh_cur[k-1] + mesh_cur[k+1];
        dg = mesh_cur[k-GRID_SIZE-1] + mesh_cur[k-GRID_SIZE+1]
           + mesh_cur[k+GRID_SIZE-1] + mesh_cur[k+GRID_SIZE+1];
        lap = n4 - 4 * m;
        nx = 2 * m - mesh_prv[k] + rnd_drop(coupling_q * lap, 16);
        avg = rnd_drop(8 * m + n4 + dg, 4);
        bl = (65536 - diffuse_q) * nx + diffuse_q * avg;
        mesh_nxt[k] = sat16(rnd_drop(bl, 16));
      end
    end
    for (int i = 0; i < CELLS; i++) begin
      mesh_prv[i] = mesh_cur[i];
      mesh_cur[i] = mesh_nxt[i];
    end
  endfunction

  function automatic void mesh_strike(input int r0, input int c0, input int h,
                                      input longint sv, input longint pa,
                                      input longint sr, input longint sc);
    int r, c, k;
    for (int dr = -h; dr <= h; dr++) begin
      for (int dc = -h; dc <= h; dc++) begin
        r = r0 + dr;
        c = c0 + dc;
        if (r >= 1 && r <= GRID_SIZE - 2 && c >= 1 && c <= GRID_SIZE - 2) begin
          k = r * GRID_SIZE + c;
          mesh_cur[k] = sv;
          mesh_prv[k] = sat16(mesh_prv[k] + pa + sr * dr + sc * dc);
        end
      end
    end
  endfunction

  // result sink stalls at random unless calm
  always @(posedge clk) begin
    if (rst) res_ch.ready <= 1'b0;
    else res_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 14);
  end

  always @(posedge clk) begin
    cell_read_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_reads.size() == 0) begin
        errors++;
        $display("%0t: unexpected read result cell=%0d prior=%0d", $time,
                 res_ch.cell_value, res_ch.prior_value);
      end else begin
        want = pending_reads.pop_front();
        n_checked++;
        if (res_ch.cell_value !== want.cell_value) begin
          errors++;
          $display("%0t: cell_value expected %0d actual %0d", $time,
                   want.cell_value, res_ch.cell_value);
        end
        if (res_ch.prior_value !== want.prior_value) begin
          errors++;
          $display("%0t: prior_value expected %0d actual %0d", $time,
                   want.prior_value, res_ch.prior_value);
        end
      end
    end
  end

  // one command transfer; valid is left high so back-to-back commands stay packed
  task automatic send_cmd(input logic [1:0] md, input int r, input int c, input int h,
                          input int sv, input int pa, input int sr, input int sc);
    cell_read_t rd;
    int k;
    if (!calm && $urandom_range(99) < 14) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    cmd_ch.valid        <= 1'b1;
    cmd_ch.mode         <= md;
    cmd_ch.row          <= 6'(r);
    cmd_ch.col          <= 6'(c);
    cmd_ch.half_size    <= 2'(h);
    cmd_ch.strike_value <= 16'(sv);
    cmd_ch.prior_add    <= 16'(pa);
    cmd_ch.slope_row    <= 16'(sr);
    cmd_ch.slope_col    <= 16'(sc);
    do @(posedge clk); while (!cmd_ch.ready);
    case (md)
      MODE_TICK: begin
        mesh_tick();
        n_ticks++;
      end
      MODE_STRIKE: begin
        mesh_strike(r & 63, c & 63, h & 3, longint'($signed(16'(sv))),
                    longint'($signed(16'(pa))), longint'($signed(16'(sr))),
                    longint'($signed(16'(sc))));
        n_strikes++;
        last_r = r & 63;
        last_c = c & 63;
      end
      MODE_READ: begin
        k = (r & 63) * GRID_SIZE + (c & 63);
        rd.cell_value  = 16'(sat16(mesh_cur[k]));
        rd.prior_value = 16'(sat16(mesh_prv[k]));
        pending_reads.insert(pending_reads.size(), rd);
        n_reads++;
      end
      default: n_idle_cmds++;
    endcase
  endtask

  task automatic drain();
    cmd_ch.valid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
  endtask

  // a read queues behind all earlier commands, so its result marks the engine idle
  task automatic settle();
    send_cmd(MODE_READ, $urandom_range(63), $urandom_range(63), 0, 0, 0, 0, 0);
    drain();
    repeat (8) @(posedge clk);
  endtask

  task automatic write_regs(input int cpl, input int dif);
    cfg_we    <= 1'b1;
    cfg_index <= REG_COUPLING;
    cfg_data  <= 16'(cpl);
    @(posedge clk);
    cfg_index <= REG_DIFFUSE;
    cfg_data  <= 16'(dif);
    @(posedge clk);
    cfg_we    <= 1'b0;
    coupling_q = cpl;
    diffuse_q  = dif;
  endtask

  task automatic read_near(input int r, input int c);
    send_cmd(MODE_READ, r, c, 0, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic test_directed();
    send_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 0);
    send_cmd(MODE_READ, 63, 63, 3, -1, -1, -1, -1);
    send_cmd(MODE_STRIKE, 10, 10, 1, 4096, 1024, 256, -256);
    read_near(10, 10);
    read_near(11, 9);
    // patch hanging over every border: off-grid and border writes dropped
    send_cmd(MODE_STRIKE, 0, 0, 3, 32767, 32767, 32767, 32767);
    send_cmd(MODE_STRIKE, 63, 62, 3, -32768, -32768, -32768, -32768);
    read_near(0, 0);
    read_near(1, 1);
    read_near(2, 3);
    read_near(62, 62);
    read_near(63, 62);
    send_cmd(MODE_STRIKE, 30, 40, 0, -32768, 32767, 0, 0);
    send_cmd(MODE_NONE, 30, 40, 3, 12345, 999, 5, 5);
    read_near(30, 40);
    send_cmd(MODE_TICK, 0, 0, 0, 0, 0, 0, 0);
    read_near(10, 10);
    read_near(9, 12);
    read_near(30, 41);
    send_cmd(MODE_TICK, 63, 63, 3, -1, -1, -1, -1);
    read_near(1, 2);
    read_near(29, 40);
    settle();
  endtask

  task automatic test_reg_extremes();
    int cpl [4] = '{0, 65535, 0, 65535};
    int dif [4] = '{0, 0, 65535, 65535};
    for (int i = 0; i < 4; i++) begin
      write_regs(cpl[i], dif[i]);
      send_cmd(MODE_STRIKE, 20, 20, 2, 8192 - 4096 * i, -2048, 300, -700);
      send_cmd(MODE_TICK, 0, 0, 0, 0, 0, 0, 0);
      read_near(20, 20);
      read_near(22, 19);
      read_near(23, 23);
      settle();
    end
  endtask

  task automatic test_random(input int n_items);
    int md, pick, r, c, sv, pa, sr, sc;
    for (int i = 0; i < n_items; i++) begin
      calm = (i >= n_items / 3) && (i < n_items / 2);
      pick = $urandom_range(99);
      if ($urandom_range(3) == 0) begin
        sv = $signed(16'($urandom)); pa = $signed(16'($urandom));
        sr = $signed(16'($urandom)); sc = $signed(16'($urandom));
      end else begin
        sv = $urandom_range(4095) - 2048; pa = $urandom_range(2047) - 1024;
        sr = $urandom_range(511) - 256;   sc = $urandom_range(511) - 256;
      end
      if (pick < 10) md = MODE_TICK;
      else if (pick < 45) md = MODE_STRIKE;
      else if (pick < 95) md = MODE_READ;
      else md = MODE_NONE;
      if (md == MODE_READ && $urandom_range(9) < 7) begin
        r = (last_r + $urandom_range(8) - 4) & 63;
        c = (last_c + $urandom_range(8) - 4) & 63;
      end else begin
        r = $urandom_range(63);
        c = $urandom_range(63);
      end
      send_cmd(2'(md), r, c, $urandom_range(3), sv, pa, sr, sc);
    end
    calm = 1'b0;
    settle();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_COUPLING;
    cfg_data = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.mode = MODE_NONE;
    cmd_ch.row = '0;
    cmd_ch.col = '0;
    cmd_ch.half_size = '0;
    cmd_ch.strike_value = '0;
    cmd_ch.prior_add = '0;
    cmd_ch.slope_row = '0;
    cmd_ch.slope_col = '0;
    errors = 0;
    calm = 1'b0;
    last_r = 10;
    last_c = 10;
    for (int i = 0; i < CELLS; i++) begin
      mesh_cur[i] = 0;
      mesh_prv[i] = 0;
    end
    coupling_q = COUPLING_RESET;
    diffuse_q  = DIFFUSE_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_reg_extremes();
    test_random(32);
    write_regs(32768, 20000);
    test_random(31);
    write_regs(6554, 3277);
    test_random(30);

    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d ticks, %0d strikes, %0d reads (%0d checked), %0d no-op commands",
             n_ticks, n_strikes, n_reads, n_checked, n_idle_cmds);
    $display("register settings included both extremes of coupling and diffuse weight");
    if (errors == 0 && pending_reads.size() == 0) begin
      $display("[wave_mesh_stencil_step] OK");
    end else begin
      $display("[wave_mesh_stencil_step] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/wms_pkg.sv
hdl/wms_in_if.sv
hdl/wms_out_if.sv
hdl/wms_ram.sv
hdl/wms_front.sv
hdl/wms_cmd_fifo.sv
hdl/wms_engine.sv
hdl/wave_mesh_stencil_step.sv
tb/tb_top.sv
